// File: design/brg_pkg.sv
// brg_pkg: shared types, constants and the microprogram for binomial_row_generator.
// No dependencies.
`default_nettype none

package brg_pkg;

    localparam int MAX_ROW    = 63;
    localparam int LANES      = MAX_ROW + 1;
    localparam int ROW_W      = 6;
    localparam int COEF_W     = 60;
    localparam int STEP_W     = 2;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_BUILD = 2'd1;
    localparam t_step STEP_EMIT  = 2'd2;

    typedef enum logic [1:0] {
        C_START       = 2'd0,
        C_ROW_PENDING = 2'd1,
        C_LAST_POS    = 2'd2,
        C_NEVER       = 2'd3
    } t_cond;

    typedef enum logic [2:0] {
        A_NONE = 3'd0,
        A_LOAD = 3'd1,
        A_ADD  = 3'd2,
        A_CLR  = 3'd3,
        A_EMIT = 3'd4
    } t_act;

    // One control word: condition selects the taken or fall-through half.
    typedef struct packed {
        t_cond cond;
        t_step next_taken;
        t_act  act_taken;
        t_step next_fall;
        t_act  act_fall;
        logic  busy;
    } t_uword;

    function automatic t_uword f_urom(input t_step step);
        t_uword w;
        unique case (step)
            STEP_IDLE:  w = '{C_START,       STEP_BUILD, A_LOAD, STEP_IDLE, A_NONE, 1'b0};
            STEP_BUILD: w = '{C_ROW_PENDING, STEP_BUILD, A_ADD,  STEP_EMIT, A_CLR,  1'b1};
            STEP_EMIT:  w = '{C_LAST_POS,    STEP_IDLE,  A_EMIT, STEP_EMIT, A_EMIT, 1'b1};
            default:    w = '{C_NEVER,       STEP_IDLE,  A_NONE, STEP_IDLE, A_NONE, 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/binomial_row_generator.sv
// binomial_row_generator: microcoded Pascal row builder and coefficient emitter.
// Depends on brg_pkg (microprogram ROM, control word type, widths).
//
// Usage:
//   Raise start with a row number n while busy is low; that edge accepts the
//   transaction. The block then builds row n in a bank of 64 lanes, one
//   additive Pascal update of all lanes per cycle, and emits C(n,0)..C(n,n)
//   one per cycle on o_coefficient/o_position, each for a single cycle with
//   o_strobe high; o_last_of_row marks the result with position n.
//   Order of work: load, the additive updates up to row n, a switch step
//   that clears the counter, then one emit step per position 0..n. busy
//   falls after the final emit step, so the next start can be taken while
//   the last result is still on the ports.
//   The loop rate is set by the three-step control program: one lane
//   update of the lane bank per build step, one shift of the lane bank per result.
//   Reset (synchronous, active low) holds busy high, returns the step counter
//   to idle and drops o_strobe; nothing is kept between rows.
//   The receiver cannot stall: each result must be taken in its strobe cycle.
`default_nettype none

module binomial_row_generator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic [brg_pkg::ROW_W-1:0]  i_row_number,
    output logic                            busy,
    output logic                            o_strobe,
    output logic [brg_pkg::COEF_W-1:0]      o_coefficient,
    output logic [brg_pkg::ROW_W-1:0]       o_position,
    output logic                            o_last_of_row
);

    brg_pkg::t_step  r_step, n_step;
    brg_pkg::t_uword uw;
    brg_pkg::t_act   act;
    logic            cond_hit;

    logic [brg_pkg::COEF_W-1:0] r_tri [brg_pkg::LANES];
    logic [brg_pkg::ROW_W-1:0]  r_n;
    logic [brg_pkg::ROW_W-1:0]  r_cnt;
    logic                       r_strobe;
    logic [brg_pkg::COEF_W-1:0] r_coef;
    logic [brg_pkg::ROW_W-1:0]  r_pos;
    logic                       r_last;
    logic [brg_pkg::ROW_W-1:0]  row_sat;

    assign uw   = brg_pkg::f_urom(r_step);
    assign busy = uw.busy | !i_rst_n;

    always_comb begin
        unique case (uw.cond)
            brg_pkg::C_START:       cond_hit = start;
            brg_pkg::C_ROW_PENDING: cond_hit = (r_cnt != r_n);
            brg_pkg::C_LAST_POS:    cond_hit = (r_cnt == r_n);
            brg_pkg::C_NEVER:       cond_hit = 1'b0;
            default:                cond_hit = 1'b0;
        endcase
        n_step = cond_hit ? uw.next_taken : uw.next_fall;
        act    = cond_hit ? uw.act_taken  : uw.act_fall;
    end

    assign row_sat = (i_row_number > brg_pkg::ROW_W'(brg_pkg::MAX_ROW))
                   ? brg_pkg::ROW_W'(brg_pkg::MAX_ROW) : i_row_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= brg_pkg::STEP_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_strobe <= (act == brg_pkg::A_EMIT);
        end
    end

    // Datapath: lane bank, counter, output register.
    always_ff @(posedge i_clk) begin
        unique case (act)
            brg_pkg::A_LOAD: begin
                r_n   <= row_sat;
                r_cnt <= '0;
                for (int k = 0; k < brg_pkg::LANES; k++) begin
                    r_tri[k] <= (k == 0) ? brg_pkg::COEF_W'(1) : '0;
                end
            end
            brg_pkg::A_ADD: begin
                // lanes 1..63 update from old values: tri[k] += tri[k-1]; lane 0 holds
                for (int k = 1; k < brg_pkg::LANES; k++) begin
                    r_tri[k] <= r_tri[k] + r_tri[k-1];
                end
                r_cnt <= r_cnt + 1'b1;
            end
            brg_pkg::A_CLR: begin
                r_cnt <= '0;
            end
            brg_pkg::A_EMIT: begin
                r_coef <= r_tri[0];
                r_pos  <= r_cnt;
                r_last <= (r_cnt == r_n);
                r_cnt  <= r_cnt + 1'b1;
                for (int k = 0; k < brg_pkg::LANES - 1; k++) begin
                    r_tri[k] <= r_tri[k+1];
                end
                r_tri[brg_pkg::LANES-1] <= '0;
            end
            brg_pkg::A_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_coefficient = r_coef;
    assign o_position    = r_pos;
    assign o_last_of_row = r_last;

endmodule

`default_nettype wire

// File: dv/tb.sv
// tb: self-checking testbench for binomial_row_generator (Pascal row emitter).
// Depends on brg_pkg and the binomial_row_generator RTL; a directed table runs first,
// then random rows, all checked against an in-bench Pascal row builder, save hand-typed directed spot values.
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_LIMIT  = 1000;
    localparam int RAND_ROWS   = 134;
    localparam int NO_SPOT     = -1;

    typedef logic [brg_pkg::COEF_W-1:0] t_coef;

    typedef struct {
        t_coef                     coefficient;
        logic [brg_pkg::ROW_W-1:0] position;
        logic                      last_of_row;
    } t_coef_result;

    // Directed row; spot_pos/spot_coef give a value typed in by hand.
    typedef struct {
        int    row;
        int    spot_pos;
        t_coef spot_coef;
    } t_row_case;

    typedef struct {
        int    pos;
        t_coef coef;
    } t_spot;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      start        = 1'b0;
    logic [brg_pkg::ROW_W-1:0] i_row_number = '0;
    logic                      busy;
    logic                      o_strobe;
    t_coef                     o_coefficient;
    logic [brg_pkg::ROW_W-1:0] o_position;
    logic                      o_last_of_row;

    t_coef_result pending_coefs[$];
    t_spot        spot_q[$];
    t_coef        row_buf [0:brg_pkg::MAX_ROW];
    t_spot        cur_spot;
    t_coef_result exp_res;

    int errors        = 0;
    int rows_sent     = 0;
    int coefs_checked = 0;
    int idle_cycles   = 0;

    t_row_case dir_cases [16] = '{
        '{0,  0,  60'd1},
        '{1,  0,  60'd1},
        '{1,  1,  60'd1},
        '{2,  1,  60'd2},
        '{63, 31, 60'd916312070471295267},
        '{63, 32, 60'd916312070471295267},
        '{63, 63, 60'd1},
        '{62, 0,  60'd1},
        '{0,  0,  60'd1},
        '{0,  0,  60'd1},
        '{3,  NO_SPOT, '0},
        '{32, NO_SPOT, '0},
        '{31, NO_SPOT, '0},
        '{42, NO_SPOT, '0},
        '{21, NO_SPOT, '0},
        '{63, 1,  60'd63}
    };

    binomial_row_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_row_number  (i_row_number),
        .busy          (busy),
        .o_strobe      (o_strobe),
        .o_coefficient (o_coefficient),
        .o_position    (o_position),
        .o_last_of_row (o_last_of_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Row n by repeated additive updates, entries past n stay zero
    function automatic void pascal_row(input int n,
                                       output t_coef tri_row [0:brg_pkg::MAX_ROW]);
        for (int k = 0; k <= brg_pkg::MAX_ROW; k++) begin
            tri_row[k] = '0;
        end
        tri_row[0] = 60'd1;
        for (int r = 1; r <= n; r++) begin
            for (int k = r; k >= 1; k--) begin
                tri_row[k] = tri_row[k] + tri_row[k-1];
            end
        end
    endfunction

    // Input transaction accepted: queue the whole row
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pascal_row(i_row_number, row_buf);
            cur_spot = spot_q.pop_front();
            for (int k = 0; k <= i_row_number; k++) begin
                exp_res.coefficient = (k == cur_spot.pos) ? cur_spot.coef : row_buf[k];
                exp_res.position    = k[brg_pkg::ROW_W-1:0];
                exp_res.last_of_row = (k == i_row_number);
                pending_coefs.push_back(exp_res);
            end
            rows_sent++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_coefs.size() == 0) begin
                $error("unexpected result: coefficient %0d position %0d",
                       o_coefficient, o_position);
                errors++;
            end else begin
                exp_res = pending_coefs.pop_front();
                coefs_checked++;
                if (o_coefficient !== exp_res.coefficient) begin
                    $error("coefficient: expected %0d, got %0d",
                           exp_res.coefficient, o_coefficient);
                    errors++;
                end
                if (o_position !== exp_res.position) begin
                    $error("position: expected %0d, got %0d", exp_res.position, o_position);
                    errors++;
                end
                if (o_last_of_row !== exp_res.last_of_row) begin
                    $error("last_of_row: expected %0d, got %0d",
                           exp_res.last_of_row, o_last_of_row);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with neither an accepted row nor a strobe
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d results pending", pending_coefs.size());
            $display("[binomial_row_generator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_row(input int row, input int spot_pos, input t_coef spot_coef,
                            input int gap);
        t_spot s;
        if (gap > 0) begin
            // idle cycles count from the point where the block is free again
            start <= 1'b0;
            @(posedge i_clk);
            while (busy !== 1'b0) @(posedge i_clk);
            repeat (gap - 1) @(posedge i_clk);
        end
        s.pos  = spot_pos;
        s.coef = spot_coef;
        spot_q.push_back(s);
        start        <= 1'b1;
        i_row_number <= row[brg_pkg::ROW_W-1:0];
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    initial begin
        int burst_left;
        int gap;
        int row;
        burst_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_cases[i]) begin
            send_row(dir_cases[i].row, dir_cases[i].spot_pos, dir_cases[i].spot_coef,
                     (i % 4 == 2) ? 0 : $urandom_range(0, 9));
        end

        for (int i = 0; i < RAND_ROWS; i++) begin
            if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(5, 15);
            end
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = $urandom_range(0, 9);
            end
            case ($urandom_range(0, 7))
                0:       row = $urandom_range(0, 1);
                1:       row = $urandom_range(brg_pkg::MAX_ROW - 1, brg_pkg::MAX_ROW);
                2:       row = $urandom_range(0, 7);
                default: row = $urandom_range(0, brg_pkg::MAX_ROW);
            endcase
            send_row(row, NO_SPOT, '0, gap);
        end
        start <= 1'b0;
        // let the last accepted row reach the expected queue
        @(posedge i_clk);

        while (pending_coefs.size() != 0) @(posedge i_clk);
        // busy drops with the final strobe; give any stray output time to show
        repeat (8) @(posedge i_clk);

        $display("rows sent: %0d (directed %0d, random %0d); coefficients checked: %0d",
                 rows_sent, $size(dir_cases), RAND_ROWS, coefs_checked);
        $display("mismatches or stray results: %0d", errors);
        if (errors == 0) begin
            $display("[binomial_row_generator] OK");
        end else begin
            $display("[binomial_row_generator] ERROR");
        end
        $finish;
    end

endmodule
